// ===== sv/rrpt_pkg.sv =====
package rrpt_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int NSTG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int XW = 36;
	localparam int ZW = 26;
	localparam int HW = 15;
	localparam logic [16:0] GAIN_Q16 = 17'd39797;
	localparam logic [16:0] MAX_DIST = 17'd131071;
	localparam logic signed [ZW-1:0] ANG_90 = ZW'(90 * 65536);
	localparam logic signed [ZW-1:0] ANG_180 = ZW'(180 * 65536);

	typedef enum logic [2:0] {
		REG_HEAD_OFFSET = 3'd0,
		REG_TEAM = 3'd1,
		REG_YGX = 3'd2,
		REG_YGY = 3'd3,
		REG_BGX = 3'd4,
		REG_BGY = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} vec_t;

	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = ZW'(2949120);
				1: r = ZW'(1740967);
				2: r = ZW'(919879);
				3: r = ZW'(466945);
				4: r = ZW'(234379);
				5: r = ZW'(117304);
				6: r = ZW'(58666);
				7: r = ZW'(29335);
				8: r = ZW'(14668);
				9: r = ZW'(7334);
				10: r = ZW'(3667);
				11: r = ZW'(1833);
				12: r = ZW'(917);
				13: r = ZW'(458);
				14: r = ZW'(229);
				15: r = ZW'(115);
				16: r = ZW'(57);
				17: r = ZW'(29);
				18: r = ZW'(14);
				19: r = ZW'(7);
				20: r = ZW'(4);
				21: r = ZW'(2);
				22: r = ZW'(1);
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/rrpt_cell.sv =====
module rrpt_cell import rrpt_pkg::*; (
	input  logic                 clk,
	input  logic [4:0]           shift,
	input  logic signed [ZW-1:0] atan,
	input  logic                 vectoring,
	input  vec_t                 din,
	output vec_t                 dout
);
	logic neg_turn;
	logic signed [XW-1:0] xs, ys;

	always_comb begin
		xs = din.x >>> shift;
		ys = din.y >>> shift;
		neg_turn = vectoring ? (din.y >= 0) : (din.z < 0);
	end

	always_ff @(posedge clk) begin
		dout.zero <= din.zero;
		if (neg_turn) begin
			dout.x <= din.x + ys;
			dout.y <= din.y - xs;
			dout.z <= din.z + atan;
		end else begin
			dout.x <= din.x - ys;
			dout.y <= din.y + xs;
			dout.z <= din.z - atan;
		end
	end
endmodule

// ===== sv/rrpt_chain.sv =====
module rrpt_chain import rrpt_pkg::*; (
	input  logic clk,
	input  logic vectoring,
	input  vec_t din,
	output vec_t dout
);
	vec_t link [NSTG+1];

	assign link[0] = din;

	for (genvar i = 0; i < NSTG; i++) begin : g_cell
		rrpt_cell u_cell (
			.clk(clk),
			.shift(5'(i)),
			.atan(atan_val(i)),
			.vectoring(vectoring),
			.din(link[i]),
			.dout(link[i+1])
		);
	end

	assign dout = link[NSTG];
endmodule

// ===== sv/rrpt_polar.sv =====
module rrpt_polar import rrpt_pkg::*; (
	input  logic                 clk,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	output logic [16:0]          mag,
	output logic signed [15:0]   dir
);
	vec_t pre_s1, post;
	logic [XW+17:0] prod_s2;
	logic signed [ZW-1:0] z_s2;
	logic zero_s2;
	logic [XW+17:0] d;
	logic signed [ZW-1:0] zr;

	always_ff @(posedge clk) begin
		pre_s1.zero <= (x == 0) && (y == 0);
		if (x < 0) begin
			pre_s1.x <= -x;
			pre_s1.y <= -y;
			pre_s1.z <= (y >= 0) ? ANG_180 : -ANG_180;
		end else begin
			pre_s1.x <= x;
			pre_s1.y <= y;
			pre_s1.z <= '0;
		end
	end

	rrpt_chain u_chain (.clk(clk), .vectoring(1'b1), .din(pre_s1), .dout(post));

	always_ff @(posedge clk) begin
		prod_s2 <= (XW+18)'(unsigned'(post.x)) * (XW+18)'(GAIN_Q16);
		z_s2 <= post.z;
		zero_s2 <= post.zero;
	end

	always_comb begin
		d = (prod_s2 + (XW+18)'(64'h8000_0000)) >> 32;
		zr = (z_s2 + ZW'(512)) >>> 10;
		if (zero_s2) begin
			mag = '0;
			dir = '0;
		end else begin
			mag = (d > (XW+18)'(MAX_DIST)) ? MAX_DIST : d[16:0];
			dir = zr[15:0];
		end
	end
endmodule

// ===== sv/robot_relative_polar_targets.sv =====
// From the accepting edge to the edge that takes the result, a word passes one register for the
// heading reduction, NSTG rotation cells, one register for the vector fold, NSTG vectoring cells
// and the gain multiply register, in that order.
// Throughput: one word per cycle; busy is always low since every cell hands on each cycle.
// Reset clears the configuration registers to their reset values and the valid line.
// The receiver cannot stall; each result is shown for exactly one cycle with done.
module robot_relative_polar_targets import rrpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         robot_index,
	input  logic signed [15:0] robot_x,
	input  logic signed [15:0] robot_y,
	input  logic signed [14:0] robot_heading,
	input  logic signed [15:0] ball_x,
	input  logic signed [15:0] ball_y,
	output logic               done,
	output logic [1:0]         tag_index,
	output logic [16:0]        ball_distance,
	output logic signed [15:0] ball_bearing,
	output logic [16:0]        attack_goal_distance,
	output logic signed [15:0] attack_goal_bearing,
	output logic [16:0]        own_goal_distance,
	output logic signed [15:0] own_goal_bearing
);
	localparam int LAT = 2 * NSTG + 3;
	localparam int LA = NSTG + 1;

	logic [9:0] head_offset_q;
	logic team_q;
	logic signed [15:0] ygx_q, ygy_q, bgx_q, bgy_q;
	logic [LAT-1:0] vld_q;
	vec_t rot_in_s1, rot_out;
	logic signed [ZW-1:0] z0;
	logic signed [XW-1:0] ox0;
	logic [1:0] idx_d [LAT];
	logic signed [HW-1:0] hd_d [LAT];
	logic signed [15:0] rx_d [LA], ry_d [LA], bx_d [LA], by_d [LA];
	logic signed [15:0] ax_d [LA], ay_d [LA], gx_d [LA], gy_d [LA];
	logic signed [XW-1:0] hx, hy;
	logic signed [XW-1:0] vx [3], vy [3];
	logic [16:0] mag [3];
	logic signed [15:0] dir [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_offset_q <= 10'd82;
			team_q <= 1'b0;
			ygx_q <= '0;
			ygy_q <= '0;
			bgx_q <= '0;
			bgy_q <= '0;
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
			if (cfg_we) begin
				case (cfg_index)
					REG_HEAD_OFFSET: head_offset_q <= cfg_data[9:0];
					REG_TEAM: team_q <= cfg_data[0];
					REG_YGX: ygx_q <= cfg_data;
					REG_YGY: ygy_q <= cfg_data;
					REG_BGX: bgx_q <= cfg_data;
					REG_BGY: bgy_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		z0 = ZW'(robot_heading) * ZW'(1024);
		ox0 = XW'(head_offset_q) * XW'(GAIN_Q16);
	end

	always_ff @(posedge clk) begin
		rot_in_s1.zero <= 1'b0;
		rot_in_s1.y <= '0;
		if (z0 > ANG_90) begin
			rot_in_s1.z <= z0 - ANG_180;
			rot_in_s1.x <= -ox0;
		end else if (z0 < -ANG_90) begin
			rot_in_s1.z <= z0 + ANG_180;
			rot_in_s1.x <= -ox0;
		end else begin
			rot_in_s1.z <= z0;
			rot_in_s1.x <= ox0;
		end
		idx_d[0] <= robot_index;
		hd_d[0] <= robot_heading;
		rx_d[0] <= robot_x;
		ry_d[0] <= robot_y;
		bx_d[0] <= ball_x;
		by_d[0] <= ball_y;
		ax_d[0] <= team_q ? bgx_q : ygx_q;
		ay_d[0] <= team_q ? bgy_q : ygy_q;
		gx_d[0] <= team_q ? ygx_q : bgx_q;
		gy_d[0] <= team_q ? ygy_q : bgy_q;
		for (int i = 1; i < LAT; i++) begin
			idx_d[i] <= idx_d[i-1];
			hd_d[i] <= hd_d[i-1];
		end
		for (int i = 1; i < LA; i++) begin
			rx_d[i] <= rx_d[i-1];
			ry_d[i] <= ry_d[i-1];
			bx_d[i] <= bx_d[i-1];
			by_d[i] <= by_d[i-1];
			ax_d[i] <= ax_d[i-1];
			ay_d[i] <= ay_d[i-1];
			gx_d[i] <= gx_d[i-1];
			gy_d[i] <= gy_d[i-1];
		end
	end

	rrpt_chain u_rot (.clk(clk), .vectoring(1'b0), .din(rot_in_s1), .dout(rot_out));

	always_comb begin
		hx = (XW'(rx_d[LA-1]) <<< 16) + rot_out.x;
		hy = (XW'(ry_d[LA-1]) <<< 16) + rot_out.y;
		vx[0] = (XW'(bx_d[LA-1]) <<< 16) - hx;
		vy[0] = (XW'(by_d[LA-1]) <<< 16) - hy;
		vx[1] = (XW'(ax_d[LA-1]) <<< 16) - hx;
		vy[1] = (XW'(ay_d[LA-1]) <<< 16) - hy;
		vx[2] = (XW'(gx_d[LA-1]) <<< 16) - hx;
		vy[2] = (XW'(gy_d[LA-1]) <<< 16) - hy;
	end

	for (genvar k = 0; k < 3; k++) begin : g_pol
		rrpt_polar u_pol (.clk(clk), .x(vx[k]), .y(vy[k]), .mag(mag[k]), .dir(dir[k]));
	end

	always_comb begin
		done = vld_q[LAT-1];
		tag_index = idx_d[LAT-1];
		ball_distance = mag[0];
		ball_bearing = dir[0] - 16'(hd_d[LAT-1]);
		attack_goal_distance = mag[1];
		attack_goal_bearing = dir[1] - 16'(hd_d[LAT-1]);
		own_goal_distance = mag[2];
		own_goal_bearing = dir[2] - 16'(hd_d[LAT-1]);
	end
endmodule

// ===== sv/rrpt_checker.sv =====
module rrpt_checker import rrpt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [16:0] ball_distance,
	input logic [16:0] attack_goal_distance,
	input logic [16:0] own_goal_distance
);
	localparam int LAT = 2 * NSTG + 3;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without word");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ball_distance <= MAX_DIST && attack_goal_distance <= MAX_DIST
		&& own_goal_distance <= MAX_DIST)) else $error("distance range");
endmodule

bind robot_relative_polar_targets rrpt_checker u_chk (.*);
